@@ hdl/ses_pkg.sv @@
`default_nettype none
package ses_pkg;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned STEP_W = 31;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PARITY   = 3'd0,
        REG_START_E  = 3'd1,
        REG_START_S  = 3'd2,
        REG_TWO_DX2  = 3'd3,
        REG_CUTOFF   = 3'd4,
        REG_PHI_C    = 3'd5,
        REG_PHI_B    = 3'd6,
        REG_POINTS   = 3'd7
    } cfg_reg_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        sample_index;
        logic signed [DATA_W-1:0] potential_value;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [DATA_W-1:0] wave_value;
        logic signed [DATA_W-1:0] energy_now;
        logic [STEP_W-1:0]        step_now;
        logic [1:0]               direction;
        logic                     last_sample;
    } res_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [DATA_W-1:0] r;
        begin
            if (v > 66'sh0_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -66'sh0_8000_0000)
                r = 32'sh8000_0000;
            else
                r = v[DATA_W-1:0];
            return r;
        end
    endfunction
endpackage
`default_nettype wire

@@ hdl/ses_if.sv @@
`default_nettype none
interface ses_req_if;
    logic          valid;
    logic          ready;
    ses_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ses_res_if;
    logic          valid;
    logic          ready;
    ses_pkg::res_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/shooting_eigenvalue_sweep.sv @@
// A load request writes one potential sample. A run request integrates the
// wavefunction outward from the centre to both ends through one shared 33x33
// multiplier. Each grid point goes through five steps: a potential read, a
// multiply by (E - V), a saturate, a multiply by two_dx_squared, then a
// subtract, saturate and store. A sweep of P points computes P - 1 of them
// with even start values and P with odd ones. Once a side diverges, its
// remaining points are clamped at one point a cycle. A set-up step, a step
// that starts the inner side, the tail read and the energy update come on
// top. The P samples then go out one at a time, each read from the wave
// store and held until the consumer is ready. The block accepts no request
// while a sweep is running or its samples are being emitted.
`default_nettype none
module shooting_eigenvalue_sweep #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [ses_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ses_pkg::DATA_W-1:0] cfg_data,
    ses_req_if.sink   req,
    ses_res_if.source res
);
    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam logic signed [31:0] CLAMP = 32'sd5 <<< (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_RDV, S_MUL1, S_MUL2, S_FIN, S_FILL, S_CLAMP, S_LEFT0,
        S_TAILRD, S_UPD, S_EMITRD, S_EMIT
    } state_t;

    // Which point is being produced in the sweep.
    typedef enum logic [2:0] {
        PH_MID, PH_SEED2, PH_ODD2, PH_RIGHT, PH_LEFT
    } phase_t;

    logic        parity_reg;
    logic [30:0] k_reg, cutoff_reg;
    logic signed [31:0] phi_c_reg, phi_b_reg;
    logic [6:0]  points_reg;

    logic signed [31:0] energy_reg;
    logic [30:0] step_reg;
    logic [30:0] dec_reg;
    logic [1:0]  dir_reg;

    logic signed [31:0] pot_mem [MAX_POINTS];
    logic signed [31:0] wave_mem [MAX_POINTS];

    state_t state_reg;
    phase_t phase_reg;
    logic [PW-1:0] p_reg;
    logic [AW-1:0] j_reg;
    logic [AW-1:0] fill_reg;
    logic [PW-1:0] emit_reg;
    logic signed [31:0] prev_reg, cur_reg, vrd_reg, t_reg, wrd_reg;
    logic signed [31:0] wmid_reg, wlo_reg;
    logic signed [63:0] prod_reg;

    // Shared multiplier.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] shifted;
    assign mul_p = mul_a * mul_b;
    assign shifted = $signed({{2{prod_reg[63]}}, prod_reg}) >>> FRAC_BITS;

    always_comb
    begin
        if (state_reg == S_MUL1)
        begin
            mul_a = {energy_reg[31], energy_reg} - {vrd_reg[31], vrd_reg};
            mul_b = {cur_reg[31], cur_reg};
        end
        else
        begin
            mul_a = {2'b00, k_reg};
            mul_b = {t_reg[31], t_reg};
        end
    end

    logic [PW-1:0] p_sat;
    always_comb
    begin
        if (points_reg < 7'd8)
            p_sat = PW'(8);
        else if (32'(points_reg) > MAX_POINTS)
            p_sat = PW'(MAX_POINTS);
        else
            p_sat = points_reg[PW-1:0];
    end

    logic signed [31:0] m_sat;
    assign m_sat = ses_pkg::sat32(shifted);
    logic signed [31:0] fd_res;
    assign fd_res = ses_pkg::sat32({{33{cur_reg[31]}}, cur_reg, 1'b0}
                                   - {{34{prev_reg[31]}}, prev_reg}
                                   - {{34{m_sat[31]}}, m_sat});
    logic signed [31:0] neg_res;
    assign neg_res = ses_pkg::sat32(-{{34{fd_res[31]}}, fd_res});
    logic [32:0] fd_abs;
    assign fd_abs = fd_res[31] ? 33'(-{fd_res[31], fd_res}) : {1'b0, fd_res};
    logic div_hit;
    assign div_hit = (fd_res != 0) && (fd_abs >= {2'b00, cutoff_reg});

    logic [AW-1:0] mid;
    assign mid = p_reg[PW-1:1];
    logic [AW-1:0] vidx;
    always_comb
    begin
        case (phase_reg)
            PH_MID:   vidx = mid - AW'(1);
            PH_SEED2: vidx = mid;
            PH_ODD2:  vidx = mid;
            PH_RIGHT: vidx = j_reg - AW'(1);
            PH_LEFT:  vidx = j_reg + AW'(1);
            default:  vidx = mid;
        endcase
    end

    logic [31:0] step2;
    logic [30:0] step_dec;
    assign step2 = {step_reg, 1'b0};
    // Exact floor division by three for any 32-bit operand.
    assign step_dec = 31'((64'(step2) * 64'hAAAA_AAAB) >> 33);

    logic [AW-1:0] wr_addr;
    logic signed [31:0] wr_data;
    logic wr_en;
    logic [AW-1:0] rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= 1'b0;
            k_reg <= '0;
            cutoff_reg <= 31'(2) << FRAC_BITS;
            phi_c_reg <= 32'sd1 <<< FRAC_BITS;
            phi_b_reg <= 32'sd1 <<< FRAC_BITS;
            points_reg <= 7'd64;
            energy_reg <= '0;
            step_reg <= 31'(1) << FRAC_BITS;
            dir_reg <= ses_pkg::DIR_NONE;
            state_reg <= S_IDLE;
            phase_reg <= PH_MID;
        end
        else
        begin
            if (cfg_we)
            begin
                case (ses_pkg::cfg_reg_t'(cfg_index))
                    ses_pkg::REG_PARITY:  parity_reg <= cfg_data[0];
                    ses_pkg::REG_START_E: energy_reg <= cfg_data;
                    ses_pkg::REG_START_S: step_reg <= cfg_data[30:0];
                    ses_pkg::REG_TWO_DX2: k_reg <= cfg_data[30:0];
                    ses_pkg::REG_CUTOFF:  cutoff_reg <= cfg_data[30:0];
                    ses_pkg::REG_PHI_C:   phi_c_reg <= cfg_data;
                    ses_pkg::REG_PHI_B:   phi_b_reg <= cfg_data;
                    ses_pkg::REG_POINTS:  points_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.payload.req_type == ses_pkg::REQ_RUN)
                    begin
                        p_reg <= p_sat;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    phase_reg <= PH_MID;
                    prev_reg <= phi_b_reg;
                    cur_reg <= phi_c_reg;
                    state_reg <= S_RDV;
                end
                S_RDV:
                begin
                    vrd_reg <= pot_mem[vidx];
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    prod_reg <= mul_p[63:0];
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    t_reg <= ses_pkg::sat32(shifted);
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    prod_reg <= mul_p[63:0];
                    state_reg <= S_FILL;
                end
                S_FILL:
                begin
                    // The second multiply is now in prod_reg; finish the point.
                    case (phase_reg)
                        PH_MID:
                        begin
                            prev_reg <= phi_c_reg;
                            cur_reg <= fd_res;
                            wmid_reg <= fd_res;
                            phase_reg <= PH_SEED2;
                            state_reg <= S_RDV;
                        end
                        PH_SEED2:
                        begin
                            if (parity_reg)
                            begin
                                // Odd start: the inner neighbour takes the negated step,
                                // and the outer one is stepped from it.
                                prev_reg <= neg_res;
                                wlo_reg <= neg_res;
                                phase_reg <= PH_ODD2;
                                state_reg <= S_RDV;
                            end
                            else
                            begin
                                wlo_reg <= fd_res;
                                j_reg <= mid + AW'(2);
                                prev_reg <= cur_reg;
                                cur_reg <= fd_res;
                                phase_reg <= PH_RIGHT;
                                state_reg <= S_RDV;
                            end
                        end
                        PH_ODD2:
                        begin
                            j_reg <= mid + AW'(2);
                            prev_reg <= cur_reg;
                            cur_reg <= fd_res;
                            phase_reg <= PH_RIGHT;
                            state_reg <= S_RDV;
                        end
                        PH_RIGHT:
                        begin
                            if (div_hit)
                            begin
                                fill_reg <= j_reg;
                                t_reg <= fd_res[31] ? -CLAMP : CLAMP;
                                state_reg <= S_CLAMP;
                            end
                            else if (32'(j_reg) + 1 < 32'(p_reg))
                            begin
                                j_reg <= j_reg + AW'(1);
                                prev_reg <= cur_reg;
                                cur_reg <= fd_res;
                                state_reg <= S_RDV;
                            end
                            else
                                state_reg <= S_LEFT0;
                        end
                        PH_LEFT:
                        begin
                            if (div_hit)
                            begin
                                fill_reg <= j_reg;
                                t_reg <= fd_res[31] ? -CLAMP : CLAMP;
                                state_reg <= S_CLAMP;
                            end
                            else if (j_reg != 0)
                            begin
                                j_reg <= j_reg - AW'(1);
                                prev_reg <= cur_reg;
                                cur_reg <= fd_res;
                                state_reg <= S_RDV;
                            end
                            else
                                state_reg <= S_TAILRD;
                        end
                        default: state_reg <= S_TAILRD;
                    endcase
                end
                S_CLAMP:
                begin
                    if (phase_reg == PH_RIGHT)
                    begin
                        if (32'(fill_reg) + 1 < 32'(p_reg))
                            fill_reg <= fill_reg + AW'(1);
                        else
                            state_reg <= S_LEFT0;
                    end
                    else
                    begin
                        if (fill_reg != 0)
                            fill_reg <= fill_reg - AW'(1);
                        else
                            state_reg <= S_TAILRD;
                    end
                end
                S_LEFT0:
                begin
                    // The inner side starts from the centre value and its inner neighbour.
                    prev_reg <= wmid_reg;
                    cur_reg <= wlo_reg;
                    j_reg <= mid - AW'(2);
                    phase_reg <= PH_LEFT;
                    state_reg <= S_RDV;
                end
                S_TAILRD:
                begin
                    wrd_reg <= wave_mem[AW'(p_reg - PW'(5))];
                    dec_reg <= step_dec;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (wrd_reg > 0)
                    begin
                        if (dir_reg == ses_pkg::DIR_DOWN)
                        begin
                            step_reg <= dec_reg;
                            energy_reg <= ses_pkg::sat32(66'(energy_reg) + 66'(dec_reg));
                        end
                        else
                            energy_reg <= ses_pkg::sat32(66'(energy_reg) + 66'(step_reg));
                    end
                    else if (wrd_reg < 0)
                    begin
                        if (dir_reg == ses_pkg::DIR_UP)
                        begin
                            step_reg <= dec_reg;
                            energy_reg <= ses_pkg::sat32(66'(energy_reg) - 66'(dec_reg));
                        end
                        else
                            energy_reg <= ses_pkg::sat32(66'(energy_reg) - 66'(step_reg));
                    end
                    dir_reg <= (wrd_reg < 0 && 33'(-{wrd_reg[31], wrd_reg}) > {2'b00, cutoff_reg})
                               ? ses_pkg::DIR_DOWN : ses_pkg::DIR_UP;
                    emit_reg <= '0;
                    state_reg <= S_EMITRD;
                end
                S_EMITRD:
                begin
                    wrd_reg <= wave_mem[emit_reg[AW-1:0]];
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (res.ready)
                    begin
                        if (emit_reg == p_reg - PW'(1))
                            state_reg <= S_IDLE;
                        else
                        begin
                            emit_reg <= emit_reg + PW'(1);
                            state_reg <= S_EMITRD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rd_addr = vidx;

    // Wave store writes: the seeds, every ordinary step, and the clamp fill.
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = rd_addr;
        wr_data = fd_res;
        case (state_reg)
            S_FILL:
            begin
                wr_en = 1'b1;
                case (phase_reg)
                    PH_MID: wr_addr = mid;
                    PH_SEED2:
                    begin
                        if (parity_reg)
                        begin
                            wr_addr = mid - AW'(1);
                            wr_data = neg_res;
                        end
                        else
                            wr_addr = mid + AW'(1);
                    end
                    PH_ODD2: wr_addr = mid + AW'(1);
                    default:
                    begin
                        wr_addr = j_reg;
                        if (div_hit)
                            wr_data = fd_res[31] ? -CLAMP : CLAMP;
                    end
                endcase
            end
            S_CLAMP:
            begin
                wr_en = 1'b1;
                wr_addr = fill_reg;
                wr_data = t_reg;
            end
            S_LEFT0:
            begin
                wr_en = 1'b1;
                wr_addr = mid - AW'(1);
                wr_data = wlo_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready && req.payload.req_type == ses_pkg::REQ_LOAD
            && 32'(req.payload.sample_index) < MAX_POINTS)
            pot_mem[req.payload.sample_index[AW-1:0]] <= req.payload.potential_value;
        if (wr_en)
            wave_mem[wr_addr] <= wr_data;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_EMIT);
    assign res.payload.out_index = ses_pkg::IDX_W'(emit_reg);
    assign res.payload.wave_value = wrd_reg;
    assign res.payload.energy_now = energy_reg;
    assign res.payload.step_now = step_reg;
    assign res.payload.direction = dir_reg;
    assign res.payload.last_sample = (emit_reg == p_reg - PW'(1));

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !req.ready) else $error("request taken while emitting");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid) else $error("sample dropped");
    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> dir_reg != ses_pkg::DIR_NONE) else $error("no direction after sweep");
endmodule
`default_nettype wire

@@ verif/sweep_checker.sv @@
`timescale 1ns / 1ps
module sweep_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ses_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ses_pkg::DATA_W-1:0]    cfg_data,
    ses_req_if                            req,
    ses_res_if                            res,
    output int                            failures,
    output int                            pending
);
    localparam int FRAC = 24;
    localparam int NPTS = 64;
    localparam logic signed [ses_pkg::DATA_W-1:0] WAVE_CLAMP = 32'sd41943040;

    logic                              odd_seed;
    logic [ses_pkg::STEP_W-1:0]        coupling;
    logic [ses_pkg::STEP_W-1:0]        blowup_limit;
    logic signed [ses_pkg::DATA_W-1:0] seed_centre;
    logic signed [ses_pkg::DATA_W-1:0] seed_before;
    logic [6:0]                        grid_points;

    logic signed [ses_pkg::DATA_W-1:0] potential [NPTS];
    logic signed [ses_pkg::DATA_W-1:0] wave [NPTS];
    logic signed [ses_pkg::DATA_W-1:0] energy;
    logic [ses_pkg::STEP_W-1:0]        energy_step;
    logic [1:0]                        heading;

    ses_pkg::res_t expected_samples [$];
    int   errors;

    assign failures = errors;

    function automatic logic signed [ses_pkg::DATA_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[ses_pkg::DATA_W-1:0];
    endfunction

    // One difference step from grid point vi, which holds cur.
    function automatic logic signed [ses_pkg::DATA_W-1:0] fd_next(
        input logic signed [ses_pkg::DATA_W-1:0] prev,
        input logic signed [ses_pkg::DATA_W-1:0] cur,
        input int vi);
        longint d;
        logic signed [ses_pkg::DATA_W-1:0] t;
        logic signed [ses_pkg::DATA_W-1:0] m;
        d = longint'(energy) - longint'(potential[vi]);
        t = clip32((d * longint'(cur)) >>> FRAC);
        m = clip32((longint'(coupling) * longint'(t)) >>> FRAC);
        return clip32(2 * longint'(cur) - longint'(prev) - longint'(m));
    endfunction

    function automatic bit blown(input logic signed [ses_pkg::DATA_W-1:0] t);
        longint a;
        a = (t < 0) ? -longint'(t) : longint'(t);
        return (t != 0) && (a >= longint'(blowup_limit));
    endfunction

    function automatic void predict_sweep();
        int p;
        int mid;
        bit hit;
        logic signed [ses_pkg::DATA_W-1:0] t;
        logic signed [ses_pkg::DATA_W-1:0] tail;
        longint shrunk;
        ses_pkg::res_t r;
        p = grid_points;
        if (p < 8)
            p = 8;
        if (p > NPTS)
            p = NPTS;
        mid = p / 2;
        wave[mid] = fd_next(seed_before, seed_centre, mid - 1);
        if (!odd_seed)
        begin
            wave[mid + 1] = fd_next(seed_centre, wave[mid], mid);
            wave[mid - 1] = wave[mid + 1];
        end
        else
        begin
            wave[mid - 1] = clip32(-longint'(fd_next(seed_centre, wave[mid], mid)));
            wave[mid + 1] = fd_next(wave[mid - 1], wave[mid], mid);
        end
        hit = 0;
        for (int j = mid + 2; j < p; j++)
        begin
            if (hit)
                wave[j] = wave[j - 1];
            else
            begin
                t = fd_next(wave[j - 2], wave[j - 1], j - 1);
                hit = blown(t);
                wave[j] = hit ? ((t > 0) ? WAVE_CLAMP : -WAVE_CLAMP) : t;
            end
        end
        hit = 0;
        for (int j = mid - 2; j >= 0; j--)
        begin
            if (hit)
                wave[j] = wave[j + 1];
            else
            begin
                t = fd_next(wave[j + 2], wave[j + 1], j + 1);
                hit = blown(t);
                wave[j] = hit ? ((t > 0) ? WAVE_CLAMP : -WAVE_CLAMP) : t;
            end
        end
        tail = wave[p - 5];
        shrunk = (2 * longint'(energy_step)) / 3;
        if (tail > 0)
        begin
            if (heading == ses_pkg::DIR_DOWN)
                energy_step = shrunk[ses_pkg::STEP_W-1:0];
            energy = clip32(longint'(energy) + longint'(energy_step));
        end
        else if (tail < 0)
        begin
            if (heading == ses_pkg::DIR_UP)
                energy_step = shrunk[ses_pkg::STEP_W-1:0];
            energy = clip32(longint'(energy) - longint'(energy_step));
        end
        heading = (tail < 0 && -longint'(tail) > longint'(blowup_limit))
                  ? ses_pkg::DIR_DOWN : ses_pkg::DIR_UP;
        for (int i = 0; i < p; i++)
        begin
            r.out_index   = i[ses_pkg::IDX_W-1:0];
            r.wave_value  = wave[i];
            r.energy_now  = energy;
            r.step_now    = energy_step;
            r.direction   = heading;
            r.last_sample = (i == p - 1);
            expected_samples.push_back(r);
        end
    endfunction

    function automatic void compare(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ses_pkg::res_t want;
        ses_pkg::res_t got;
        if (!rst_n)
        begin
            odd_seed     = 1'b0;
            coupling     = '0;
            blowup_limit = 31'd33554432;
            seed_centre  = 32'sd16777216;
            seed_before  = 32'sd16777216;
            grid_points  = 7'd64;
            energy       = '0;
            energy_step  = 31'd16777216;
            heading      = ses_pkg::DIR_NONE;
            errors       = 0;
            expected_samples.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (ses_pkg::cfg_reg_t'(cfg_index))
                    ses_pkg::REG_PARITY:  odd_seed = cfg_data[0];
                    ses_pkg::REG_START_E: energy = cfg_data;
                    ses_pkg::REG_START_S: energy_step = cfg_data[ses_pkg::STEP_W-1:0];
                    ses_pkg::REG_TWO_DX2: coupling = cfg_data[ses_pkg::STEP_W-1:0];
                    ses_pkg::REG_CUTOFF:  blowup_limit = cfg_data[ses_pkg::STEP_W-1:0];
                    ses_pkg::REG_PHI_C:   seed_centre = cfg_data;
                    ses_pkg::REG_PHI_B:   seed_before = cfg_data;
                    ses_pkg::REG_POINTS:  grid_points = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                if (req.payload.req_type == ses_pkg::REQ_LOAD)
                    potential[req.payload.sample_index] = req.payload.potential_value;
                else
                    predict_sweep();
            end
            if (res.valid && res.ready)
            begin
                got = res.payload;
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected sample at index %0d", got.out_index);
                    errors++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    compare("out_index", want.out_index, got.out_index);
                    compare("wave_value", want.wave_value, got.wave_value);
                    compare("energy_now", want.energy_now, got.energy_now);
                    compare("step_now", want.step_now, got.step_now);
                    compare("direction", want.direction, got.direction);
                    compare("last_sample", want.last_sample, got.last_sample);
                end
            end
            pending = expected_samples.size();
        end
    end
endmodule

@@ verif/shooting_eigenvalue_sweep_tb.sv @@
`timescale 1ns / 1ps
module shooting_eigenvalue_sweep_tb;
    localparam int LIMIT = 4000000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ses_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ses_pkg::DATA_W-1:0]    cfg_data;
    int                            failures;
    int                            pending;
    int                            mode;
    int                            hold_left;
    logic                          hold_kick;
    int                            cycles = 0;
    int                            loads;
    int                            sweeps;
    int                            phases;

    ses_req_if req_ch ();
    ses_res_if res_ch ();

    shooting_eigenvalue_sweep dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    sweep_checker sweep_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch),
        .failures  (failures),
        .pending   (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("shooting_eigenvalue_sweep test failed");
            $finish;
        end
    end

    // Long receiver hold-off, counted down in cycles once kicked off.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // The receiver stalls by mode, and a pending hold-off keeps it stalled outright.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
            res_ch.ready <= 1'b0;
        else if (mode == 2)
            res_ch.ready <= ($urandom_range(99) >= 68);
        else if (mode == 3)
            res_ch.ready <= ($urandom_range(99) >= 10);
        else
            res_ch.ready <= 1'b1;
    end

    task automatic cfg_put(input ses_pkg::cfg_reg_t idx, input logic [ses_pkg::DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic apply_settings(input bit par, input logic signed [ses_pkg::DATA_W-1:0] e,
                                  input logic [ses_pkg::STEP_W-1:0] s,
                                  input logic [ses_pkg::STEP_W-1:0] k,
                                  input logic [ses_pkg::STEP_W-1:0] c,
                                  input logic signed [ses_pkg::DATA_W-1:0] pc,
                                  input logic signed [ses_pkg::DATA_W-1:0] pb,
                                  input logic [6:0] pts);
        req_ch.valid <= 1'b0;
        cfg_put(ses_pkg::REG_PARITY, {31'd0, par});
        cfg_put(ses_pkg::REG_START_E, e);
        cfg_put(ses_pkg::REG_START_S, {1'b0, s});
        cfg_put(ses_pkg::REG_TWO_DX2, {1'b0, k});
        cfg_put(ses_pkg::REG_CUTOFF, {1'b0, c});
        cfg_put(ses_pkg::REG_PHI_C, pc);
        cfg_put(ses_pkg::REG_PHI_B, pb);
        cfg_put(ses_pkg::REG_POINTS, {25'd0, pts});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send(input ses_pkg::req_t r);
        int gap_pct;
        gap_pct = (mode == 1) ? 68 : (mode == 3) ? 10 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (r.req_type == ses_pkg::REQ_LOAD)
            loads++;
        else
            sweeps++;
    endtask

    task automatic load(input int idx, input logic signed [ses_pkg::DATA_W-1:0] v);
        ses_pkg::req_t r;
        r.req_type        = ses_pkg::REQ_LOAD;
        r.sample_index    = idx[ses_pkg::IDX_W-1:0];
        r.potential_value = v;
        send(r);
    endtask

    task automatic sweep();
        ses_pkg::req_t r;
        r.req_type        = ses_pkg::REQ_RUN;
        r.sample_index    = 6'($urandom);
        r.potential_value = $urandom;
        send(r);
    endtask

    // Drop valid and wait until every expected sample has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [ses_pkg::DATA_W-1:0] pick(input int unsigned lo,
                                                        input int unsigned hi);
        if ($urandom_range(5) == 0)
            return $urandom;
        return $urandom_range(hi, lo);
    endfunction

    function automatic logic [ses_pkg::DATA_W-1:0] small_signed(input int unsigned span);
        if ($urandom_range(5) == 0)
            return $urandom;
        return $urandom_range(2 * span) - span;
    endfunction

    initial
    begin
        logic [6:0] pts;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        mode           = 0;
        hold_kick      = 1'b0;
        loads          = 0;
        sweeps         = 0;
        phases         = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole potential store first, so that no sweep reads an unwritten entry.
        for (int i = 0; i < 64; i++)
        begin
            case (i)
                0: load(i, 32'sh7FFF_FFFF);
                1: load(i, 32'sh8000_0000);
                2: load(i, 0);
                3: load(i, -1);
                default: load(i, small_signed(1 << 24));
            endcase
        end

        apply_settings(0, 32'sd8388608, 31'd16777216, 31'd167772, 31'd33554432,
                       32'sd16777216, 32'sd16777216, 7'd16);
        repeat (3) sweep();
        drain();
        apply_settings(1, 32'sd8388608, 31'd16777216, 31'd167772, 31'd33554432,
                       32'sd16777216, 32'sd16777216, 7'd8);
        repeat (2) sweep();
        drain();
        // All-zero seeds with no coupling leave a zero tail.
        apply_settings(0, 0, 31'd16777216, 31'd0, 31'd33554432, 0, 0, 7'd8);
        sweep();
        drain();
        // A zero cutoff clamps every nonzero step beyond the seeds; a points value of zero saturates to eight.
        apply_settings(1, -32'sd16777216, 31'd0, 31'd16777216, 31'd0,
                       32'sd16777216, -32'sd16777216, 7'd0);
        sweep();
        drain();
        apply_settings(0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                       32'sh7FFF_FFFF, 32'sh8000_0000, 7'd127);
        repeat (2) sweep();
        drain();
        apply_settings(1, 32'sh8000_0000, 31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF,
                       32'sh8000_0000, 32'sh7FFF_FFFF, 7'd64);
        sweep();
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            phases++;
            mode = ph % 4;
            pts = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(16, 8));
            apply_settings(1'($urandom_range(1)), small_signed(1 << 25),
                           31'(pick(0, 1 << 25)), 31'(pick(0, 1 << 21)),
                           31'(pick(1 << 23, 1 << 26)),
                           small_signed(1 << 25), small_signed(1 << 25), pts);
            if (ph == 4)
            begin
                // Long receiver hold-off while sweeps keep coming, so the input backs up.
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
                repeat (3) sweep();
            end
            for (int n = 0; n < 25; n++)
            begin
                if (n == 12)
                    drain();
                if ($urandom_range(99) < 30)
                    sweep();
                else
                    load($urandom_range(63), small_signed(1 << 25));
            end
            drain();
        end

        $display("Covered %0d potential loads and %0d sweeps over %0d random phases.",
                 loads, sweeps, phases);
        if (failures == 0)
            $display("shooting_eigenvalue_sweep test passed");
        else
            $display("shooting_eigenvalue_sweep test failed");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/ses_pkg.sv
hdl/ses_if.sv
hdl/shooting_eigenvalue_sweep.sv
verif/sweep_checker.sv
verif/shooting_eigenvalue_sweep_tb.sv
